// ===== sv/deq_pkg.sv =====
package deq_pkg;

    // Ring geometry and word width.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Action codes carried by an input item.
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_AT    = 3'd4,
        ACT_WRITE_AT   = 3'd5
    } action_t;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    // One input item.
    typedef struct packed {
        action_t action;
        word_t   value;
        idx_t    position;
    } cmd_item_t;

    // One result item.
    typedef struct packed {
        word_t read_data;
        word_t front_value;
        word_t back_value;
        cnt_t  count;
        logic  empty_res;
        logic  full_res;
        logic  rejected;
    } res_item_t;

    // Request from the control logic to the entry memory.
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        logic  rd_en;
        idx_t  rd_addr;
    } mem_req_t;

endpackage

// ===== sv/deq_mem.sv =====
module deq_mem
    import deq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output word_t    rd_data
);

    word_t mem_array [DEPTH];
    word_t rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/deq_core.sv =====
module deq_core
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic      advance,
    input  cmd_item_t cmd,
    input  word_t     rd_data,
    output mem_req_t  req,
    output logic      stage_valid,
    output res_item_t stage_res
);

    idx_t  head_reg, head_next;
    cnt_t  cnt_reg, cnt_next;
    word_t front_reg, front_next;
    word_t back_reg, back_next;
    logic  fix_front_reg, fix_front_next;
    logic  fix_back_reg, fix_back_next;
    logic  a_valid_reg;
    logic  a_read_ok_reg, a_read_ok_next;
    logic  a_rej_reg, a_rej_next;

    word_t front_eff;
    word_t back_eff;
    logic  not_full;
    logic  not_empty;
    logic  pos_ok;
    idx_t  tail_slot;
    idx_t  last_slot;
    idx_t  pos_slot;
    idx_t  cnt_idx;

    // After a pop the new end value arrives from memory in the next cycle.
    assign front_eff = fix_front_reg ? rd_data : front_reg;
    assign back_eff  = fix_back_reg ? rd_data : back_reg;

    assign not_full  = (cnt_reg != CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pos_ok    = ({1'b0, cmd.position} < cnt_reg);
    assign cnt_idx   = IDX_W'(cnt_reg);
    assign tail_slot = head_reg + cnt_idx;
    assign last_slot = head_reg + cnt_idx - IDX_W'(1);
    assign pos_slot  = head_reg + cmd.position;

    // Decode the accepted item into state updates and at most one memory access.
    always_comb
    begin
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        front_next     = front_eff;
        back_next      = back_eff;
        fix_front_next = 1'b0;
        fix_back_next  = 1'b0;
        a_read_ok_next = 1'b0;
        a_rej_next     = 1'b0;
        req            = '0;
        req.wr_data    = cmd.value;
        if (take)
        begin
            unique case (cmd.action)
                ACT_PUSH_FRONT:
                begin
                    if (not_full)
                    begin
                        head_next   = head_reg - IDX_W'(1);
                        cnt_next    = cnt_reg + CNT_W'(1);
                        req.wr_en   = 1'b1;
                        req.wr_addr = head_reg - IDX_W'(1);
                        front_next  = cmd.value;
                        if (!not_empty)
                        begin
                            back_next = cmd.value;
                        end
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (not_full)
                    begin
                        cnt_next    = cnt_reg + CNT_W'(1);
                        req.wr_en   = 1'b1;
                        req.wr_addr = tail_slot;
                        back_next   = cmd.value;
                        if (!not_empty)
                        begin
                            front_next = cmd.value;
                        end
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (not_empty)
                    begin
                        head_next = head_reg + IDX_W'(1);
                        cnt_next  = cnt_reg - CNT_W'(1);
                        if (cnt_reg != CNT_W'(1))
                        begin
                            req.rd_en      = 1'b1;
                            req.rd_addr    = head_reg + IDX_W'(1);
                            fix_front_next = 1'b1;
                        end
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                ACT_POP_BACK:
                begin
                    if (not_empty)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (cnt_reg != CNT_W'(1))
                        begin
                            req.rd_en     = 1'b1;
                            req.rd_addr   = last_slot - IDX_W'(1);
                            fix_back_next = 1'b1;
                        end
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                ACT_READ_AT:
                begin
                    if (pos_ok)
                    begin
                        req.rd_en      = 1'b1;
                        req.rd_addr    = pos_slot;
                        a_read_ok_next = 1'b1;
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                ACT_WRITE_AT:
                begin
                    if (pos_ok)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = pos_slot;
                        if (cmd.position == '0)
                        begin
                            front_next = cmd.value;
                        end
                        if (cmd.position == last_slot - head_reg)
                        begin
                            back_next = cmd.value;
                        end
                    end
                    else
                    begin
                        a_rej_next = 1'b1;
                    end
                end
                default:
                begin
                    a_rej_next = 1'b1;
                end
            endcase
        end
    end

    // Pointer, count and stage flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            fix_front_reg <= 1'b0;
            fix_back_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            fix_front_reg <= fix_front_next;
            fix_back_reg  <= fix_back_next;
            if (take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // End-value caches and per-item outcome.
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (take)
        begin
            a_read_ok_reg <= a_read_ok_next;
            a_rej_reg     <= a_rej_next;
        end
    end

    // The state seen while the item waits here is the state after it.
    always_comb
    begin
        stage_res.read_data   = a_read_ok_reg ? rd_data : '0;
        stage_res.front_value = not_empty ? front_eff : '0;
        stage_res.back_value  = not_empty ? back_eff : '0;
        stage_res.count       = cnt_reg;
        stage_res.empty_res   = !not_empty;
        stage_res.full_res    = !not_full;
        stage_res.rejected    = a_rej_reg;
    end

    assign stage_valid = a_valid_reg;

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Double-ended queue of signed words held in a ring of DEPTH entries.
// The cmd channel carries one item per action: push or pop at either end,
// or read or write the element at a position counted from the front.
// The res channel returns exactly one item per command, in order, with the
// word read, the front and back values, the count, empty and full flags
// and a rejected flag for actions that were ignored.
// An accepted command passes through the memory read stage and then the
// result register before its result is valid on the res channel.
// One command per cycle is accepted while cmd_stall is low. Each command
// touches at most one memory entry; the front and back values live in
// registers, and after a pop the new end value is read from the entry memory
// at the accepting edge and taken into the end register in the next cycle.
// Two stages follow the input: the memory read stage and the result
// register. While the result register is stalled and full, one more item
// can still be accepted; cmd_stall rises when both stages hold items and
// the receiver stalls.
// Reset empties the queue at once; no clearing pass is needed, since only
// stored elements can ever be addressed.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    mem_req_t  req;
    word_t     rd_data;
    logic      take;
    logic      advance;
    logic      stage_valid;
    res_item_t stage_res;
    logic      b_valid_reg;
    res_item_t b_item_reg;

    // Handshake between the memory stage and the result register.
    assign advance   = !b_valid_reg || !res_stall;
    assign cmd_stall = stage_valid && !advance;
    assign take      = cmd_valid && !cmd_stall;

    deq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .advance     (advance),
        .cmd         (cmd),
        .rd_data     (rd_data),
        .req         (req),
        .stage_valid (stage_valid),
        .stage_res   (stage_res)
    );

    deq_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (stage_valid && advance)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid && advance)
        begin
            b_item_reg <= stage_res;
        end
    end

    assign res_valid = b_valid_reg;
    assign res       = b_item_reg;

    // The count never exceeds the ring capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.count <= CNT_W'(DEPTH)))
        else $error("count above capacity");

    // An empty queue reports zero ends and zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.empty_res) |->
            (res.count == '0 && res.front_value == '0 && res.back_value == '0))
        else $error("empty result with stale contents");

    // A rejected action never returns read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.rejected) |-> (res.read_data == '0))
        else $error("rejected item carries read data");

    // Input is held off only while both stages hold items and the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (stage_valid && b_valid_reg && res_stall))
        else $error("input stalled without a full pipeline");

endmodule

// ===== verif/tb_double_ended_queue_unit.sv =====
module tb_double_ended_queue_unit
    import deq_pkg::*;
();

    // Action codes that the block does not define; both must be rejected.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS  = 1950;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 200;

    // Direction in which a burst of random items pushes the element count.
    typedef enum int {
        DRIFT_FILL,
        DRIFT_DRAIN,
        DRIFT_CHURN
    } drift_t;

    // One row of the directed table; pinned rows carry a typed-in result.
    typedef struct {
        cmd_item_t item;
        bit        pinned;
        res_item_t want;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    // Shadow copy of the queue contents used for prediction.
    word_t ring_words [DEPTH];
    idx_t  ring_head = '0;
    int    ring_count = 0;

    res_item_t     pending_status[$];
    directed_row_t directed_rows[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int result_index = 0;
    int cycle_count = 0;

    double_ended_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Ring slot of the element at a given offset from the front.
    function automatic idx_t ring_slot(int offset);
        return idx_t'((ring_head + offset) % DEPTH);
    endfunction

    // Applies one action to the shadow queue and returns the status it reports.
    function automatic res_item_t deque_step(cmd_item_t c);
        res_item_t r;
        r = '0;
        case (c.action)
            ACT_PUSH_FRONT:
                if (ring_count >= DEPTH)
                    r.rejected = 1'b1;
                else
                begin
                    ring_head = idx_t'((ring_head + DEPTH - 1) % DEPTH);
                    ring_words[ring_head] = c.value;
                    ring_count++;
                end
            ACT_PUSH_BACK:
                if (ring_count >= DEPTH)
                    r.rejected = 1'b1;
                else
                begin
                    ring_words[ring_slot(ring_count)] = c.value;
                    ring_count++;
                end
            ACT_POP_FRONT:
                if (ring_count == 0)
                    r.rejected = 1'b1;
                else
                begin
                    ring_head = ring_slot(1);
                    ring_count--;
                end
            ACT_POP_BACK:
                if (ring_count == 0)
                    r.rejected = 1'b1;
                else
                    ring_count--;
            ACT_READ_AT:
                if (c.position >= ring_count)
                    r.rejected = 1'b1;
                else
                    r.read_data = ring_words[ring_slot(c.position)];
            ACT_WRITE_AT:
                if (c.position >= ring_count)
                    r.rejected = 1'b1;
                else
                    ring_words[ring_slot(c.position)] = c.value;
            default:
                r.rejected = 1'b1;
        endcase
        if (ring_count != 0)
        begin
            r.front_value = ring_words[ring_head];
            r.back_value  = ring_words[ring_slot(ring_count - 1)];
        end
        r.count     = cnt_t'(ring_count);
        r.empty_res = (ring_count == 0);
        r.full_res  = (ring_count == DEPTH);
        return r;
    endfunction

    function automatic cmd_item_t cmd_of(logic [2:0] act, word_t v, idx_t p);
        cmd_item_t c;
        c.action   = action_t'(act);
        c.value    = v;
        c.position = p;
        return c;
    endfunction

    // Status as read off by hand; the flags follow from the count.
    function automatic res_item_t status_of(word_t rd, word_t fv, word_t bv, int n, bit rej);
        res_item_t r;
        r.read_data   = rd;
        r.front_value = fv;
        r.back_value  = bv;
        r.count       = cnt_t'(n);
        r.empty_res   = (n == 0);
        r.full_res    = (n == DEPTH);
        r.rejected    = rej;
        return r;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(cmd_item_t item, bit pinned, res_item_t want);
        directed_row_t row;
        row.item   = item;
        row.pinned = pinned;
        row.want   = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Words lean toward the extremes now and then.
    function automatic word_t random_word();
        if ($urandom_range(99) >= 12)
            return word_t'($urandom);
        case ($urandom_range(3))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'(0);
            default: return word_t'(-1);
        endcase
    endfunction

    // Mostly a stored position, sometimes any position at all.
    function automatic idx_t random_position();
        if (ring_count > 0 && $urandom_range(99) < 85)
            return idx_t'($urandom_range(ring_count - 1));
        return idx_t'($urandom);
    endfunction

    function automatic cmd_item_t random_cmd(drift_t drift);
        cmd_item_t c;
        int        roll;
        int        push_w;
        int        pop_w;
        push_w = (drift == DRIFT_FILL) ? 75 : (drift == DRIFT_DRAIN) ? 10 : 30;
        pop_w  = (drift == DRIFT_FILL) ? 10 : (drift == DRIFT_DRAIN) ? 75 : 30;
        roll = $urandom_range(99);
        c.value    = random_word();
        c.position = random_position();
        if (roll < 2)
            c.action = action_t'($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B);
        else if (roll < 2 + push_w)
            c.action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else if (roll < 2 + push_w + pop_w)
            c.action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
        else
            c.action = $urandom_range(1) ? ACT_READ_AT : ACT_WRITE_AT;
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("result %0d: %s got %h expected %h", result_index, what, got, want);
    endtask

    // Drives one item, with an optional idle gap, and predicts at acceptance.
    task automatic send_cmd(cmd_item_t c, bit pinned, res_item_t typed);
        res_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = deque_step(c);
        pending_status.insert(pending_status.size(), pinned ? typed : predicted);
    endtask

    // Result side: random stall, and a field-by-field check of each item taken.
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("result with nothing pending", 64'(res.count), 64'(0));
                else
                begin
                    want = pending_status[0];
                    pending_status.delete(0);
                    if (res.read_data !== want.read_data)
                        report_mismatch("read_data", 64'(res.read_data),
                                        64'(want.read_data));
                    if (res.front_value !== want.front_value)
                        report_mismatch("front_value", 64'(res.front_value),
                                        64'(want.front_value));
                    if (res.back_value !== want.back_value)
                        report_mismatch("back_value", 64'(res.back_value),
                                        64'(want.back_value));
                    if (res.count !== want.count)
                        report_mismatch("count", 64'(res.count), 64'(want.count));
                    if (res.empty_res !== want.empty_res)
                        report_mismatch("empty_res", 64'(res.empty_res),
                                        64'(want.empty_res));
                    if (res.full_res !== want.full_res)
                        report_mismatch("full_res", 64'(res.full_res), 64'(want.full_res));
                    if (res.rejected !== want.rejected)
                        report_mismatch("rejected", 64'(res.rejected), 64'(want.rejected));
                end
                result_index++;
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        drift_t        drift;
        int            burst;
        int            sent;
        int            drain_wait;

        // Empty queue: every removal, access and spare code is rejected.
        add_row(cmd_of(ACT_POP_FRONT, 0, 0), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_POP_BACK, 0, 0), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_READ_AT, 0, 0), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_WRITE_AT, WORD_MIN, 63), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_SPARE_A, 0, 0), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_SPARE_B, WORD_MAX, 63), 1'b1, status_of(0, 0, 0, 0, 1));
        // Extreme words at both ends; the front push wraps the head around.
        add_row(cmd_of(ACT_PUSH_BACK, WORD_MAX, 0), 1'b1,
                status_of(0, WORD_MAX, WORD_MAX, 1, 0));
        add_row(cmd_of(ACT_PUSH_FRONT, WORD_MIN, 0), 1'b1,
                status_of(0, WORD_MIN, WORD_MAX, 2, 0));
        add_row(cmd_of(ACT_READ_AT, 0, 0), 1'b1,
                status_of(WORD_MIN, WORD_MIN, WORD_MAX, 2, 0));
        add_row(cmd_of(ACT_READ_AT, 0, 1), 1'b1,
                status_of(WORD_MAX, WORD_MIN, WORD_MAX, 2, 0));
        // Position equal to the count and the largest position are out of range.
        add_row(cmd_of(ACT_READ_AT, 0, 2), 1'b1, status_of(0, WORD_MIN, WORD_MAX, 2, 1));
        add_row(cmd_of(ACT_WRITE_AT, -1, 1), 1'b1, status_of(0, WORD_MIN, -1, 2, 0));
        add_row(cmd_of(ACT_READ_AT, 0, 63), 1'b1, status_of(0, WORD_MIN, -1, 2, 1));
        add_row(cmd_of(ACT_PUSH_FRONT, 0, 0), 1'b0, '0);
        add_row(cmd_of(ACT_PUSH_BACK, 32'sh1234_5678, 0), 1'b0, '0);
        add_row(cmd_of(ACT_WRITE_AT, WORD_MAX, 0), 1'b0, '0);
        add_row(cmd_of(ACT_READ_AT, 0, 3), 1'b0, '0);
        add_row(cmd_of(ACT_POP_BACK, 0, 0), 1'b0, '0);
        add_row(cmd_of(ACT_POP_FRONT, 0, 0), 1'b0, '0);
        add_row(cmd_of(ACT_POP_FRONT, 0, 0), 1'b0, '0);
        // Last element removed from the back, then a pop on the empty queue.
        add_row(cmd_of(ACT_POP_BACK, 0, 0), 1'b1, status_of(0, 0, 0, 0, 0));
        add_row(cmd_of(ACT_POP_BACK, 0, 0), 1'b1, status_of(0, 0, 0, 0, 1));
        add_row(cmd_of(ACT_PUSH_FRONT, -1, 0), 1'b1, status_of(0, -1, -1, 1, 0));
        add_row(cmd_of(ACT_POP_FRONT, 0, 0), 1'b1, status_of(0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);

        // Random bursts that fill, drain or churn the queue, under each idling mix.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 4)
            begin
                drift = drift_t'($urandom_range(2));
                burst = $urandom_range(20, 150);
                for (int k = 0; k < burst && sent < RANDOM_ITEMS / 4; k++)
                begin
                    send_cmd(random_cmd(drift), 1'b0, '0);
                    sent++;
                end
            end
        end

        // Let every outstanding result come back.
        cmd_valid <= 1'b0;
        recv_stall_pct = 0;
        drain_wait = 0;
        while (pending_status.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_status.size() != 0)
            report_mismatch("results never returned", 64'(pending_status.size()), 64'(0));

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
